/* hdl/dhc_pkg.sv */
// ----------------------------------------------------------------------------
// dhc_pkg
// Shared types and constants of the dock handshake controller.
// ----------------------------------------------------------------------------
package dhc_pkg;

   localparam int AVG_SAMPLES = 4;
   localparam int MV_MAX = 20884;

   localparam int SUM_W = $clog2(AVG_SAMPLES * MV_MAX + 1);
   localparam int CNT_W = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;
   localparam int AVG_LOG = $clog2(AVG_SAMPLES);
   localparam int AVG_SHIFT = SUM_W + AVG_LOG;
   localparam int AVG_RECIP_W = SUM_W + 1;
   localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
      AVG_RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));
   localparam int AVG_PROD_W = SUM_W + AVG_RECIP_W;

   localparam logic [14:0] MV_SCALE = 15'd20889;
   localparam logic [26:0] MV_ROUND = 27'd2048;

   localparam int BLINK_SHIFT = 37;
   localparam logic [30:0] BLINK_RECIP = 31'(((64'd1 << BLINK_SHIFT) + 64'd124) / 64'd125);

   localparam logic [31:0] DOCK_SETTLE_MS = 32'd200;

   localparam logic [2:0] MODE_SEARCHING = 3'd0;
   localparam logic [2:0] MODE_ALIGNING = 3'd1;
   localparam logic [2:0] MODE_DOCKED = 3'd2;
   localparam logic [2:0] MODE_CHARGING = 3'd3;
   localparam logic [2:0] MODE_STANDBY = 3'd4;

   localparam logic [2:0] REG_PRESENT_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_LOST_THRESHOLD = 3'd1;
   localparam logic [2:0] REG_DEBOUNCE = 3'd2;
   localparam logic [2:0] REG_LOST_TIMEOUT = 3'd3;
   localparam logic [2:0] REG_FULL_CHARGE = 3'd4;
   localparam logic [2:0] REG_ALIGN_TIMEOUT = 3'd5;
   localparam logic [2:0] REG_MAX_CHARGE = 3'd6;
   localparam logic [2:0] REG_STANDBY = 3'd7;

   typedef struct packed {
      logic [15:0] present_threshold_mv;
      logic [15:0] lost_threshold_mv;
      logic [15:0] debounce_ms;
      logic [31:0] lost_timeout_ms;
      logic [6:0]  full_charge_pct;
      logic [31:0] align_timeout_ms;
      logic [31:0] max_charge_ms;
      logic [31:0] standby_ms;
   } dhc_cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [14:0] mv;
      logic        beacon_level;
      logic [6:0]  battery_pct;
      logic        blink;
   } dhc_tick_type;

endpackage

/* hdl/dhc_req_if.sv */
// ----------------------------------------------------------------------------
// dhc_req_if
// Tick channel into the dock handshake controller.
// ----------------------------------------------------------------------------
interface dhc_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] now_ms;
   logic [11:0] adc_sample;
   logic        adc_ok;
   logic        ir_pin;
   logic [6:0]  battery_pct;

   modport source (output valid, output now_ms, output adc_sample, output adc_ok,
                   output ir_pin, output battery_pct, input ready);
   modport sink (input valid, input now_ms, input adc_sample, input adc_ok,
                 input ir_pin, input battery_pct, output ready);
endinterface

/* hdl/dhc_rsp_if.sv */
// ----------------------------------------------------------------------------
// dhc_rsp_if
// Result channel out of the dock handshake controller.
// ----------------------------------------------------------------------------
interface dhc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  dock_state;
   logic        charger_on;
   logic        led_on;
   logic        standby_pulse;
   logic [14:0] rail_mv;

   modport source (output valid, output dock_state, output charger_on, output led_on,
                   output standby_pulse, output rail_mv, input ready);
   modport sink (input valid, input dock_state, input charger_on, input led_on,
                 input standby_pulse, input rail_mv, output ready);
endinterface

/* hdl/dhc_csr.sv */
// ----------------------------------------------------------------------------
// dhc_csr
// Configuration registers, written by index, reset to their defaults.
// ----------------------------------------------------------------------------
module dhc_csr
   import dhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output dhc_cfg_type cfg
);

   dhc_cfg_type cfg_ff;
   dhc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PRESENT_THRESHOLD: cfg_in.present_threshold_mv = csr_wdata[15:0];
            REG_LOST_THRESHOLD:    cfg_in.lost_threshold_mv = csr_wdata[15:0];
            REG_DEBOUNCE:          cfg_in.debounce_ms = csr_wdata[15:0];
            REG_LOST_TIMEOUT:      cfg_in.lost_timeout_ms = csr_wdata;
            REG_FULL_CHARGE:       cfg_in.full_charge_pct = csr_wdata[6:0];
            REG_ALIGN_TIMEOUT:     cfg_in.align_timeout_ms = csr_wdata;
            REG_MAX_CHARGE:        cfg_in.max_charge_ms = csr_wdata;
            REG_STANDBY:           cfg_in.standby_ms = csr_wdata;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.present_threshold_mv <= 16'd15000;
         cfg_ff.lost_threshold_mv    <= 16'd5000;
         cfg_ff.debounce_ms          <= 16'd50;
         cfg_ff.lost_timeout_ms      <= 32'd1000;
         cfg_ff.full_charge_pct      <= 7'd98;
         cfg_ff.align_timeout_ms     <= 32'd500;
         cfg_ff.max_charge_ms        <= 32'd21600000;
         cfg_ff.standby_ms           <= 32'd60000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/dhc_front.sv */
// ----------------------------------------------------------------------------
// dhc_front
// Input register: converts the rail sample to mV and derives the blink phase.
// ----------------------------------------------------------------------------
module dhc_front
   import dhc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   dhc_req_if.sink      req_ch,
   input  logic         core_take,
   output logic         tick_valid,
   output dhc_tick_type tick
);

   logic         valid_ff;
   logic         valid_in;
   dhc_tick_type tick_ff;
   dhc_tick_type tick_in;
   logic         load;
   logic [26:0]  mv_prod;
   logic [60:0]  blink_prod;

   assign req_ch.ready = !valid_ff || core_take;
   assign load = req_ch.valid && req_ch.ready;

   // mV = (adc * 20889 + 2048) >> 12
   assign mv_prod = 27'(req_ch.adc_sample) * 27'(MV_SCALE) + MV_ROUND;
   // bit 0 of now / 500, as (now >> 2) / 125 by reciprocal
   assign blink_prod = 61'(req_ch.now_ms[31:2]) * 61'(BLINK_RECIP);

   always_comb begin
      tick_in.now_ms = req_ch.now_ms;
      tick_in.mv = req_ch.adc_ok ? mv_prod[26:12] : 15'd0;
      tick_in.beacon_level = !req_ch.ir_pin;
      tick_in.battery_pct = req_ch.battery_pct;
      tick_in.blink = blink_prod[BLINK_SHIFT];
      valid_in = load || (valid_ff && !core_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tick_ff <= tick_in;
      end
   end

   assign tick_valid = valid_ff;
   assign tick = tick_ff;

endmodule

/* hdl/dhc_core.sv */
// ----------------------------------------------------------------------------
// dhc_core
// Averager, beacon debounce, dock state machine and result register.
// ----------------------------------------------------------------------------
module dhc_core
   import dhc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  dhc_cfg_type  cfg,
   input  logic         tick_valid,
   input  dhc_tick_type tick,
   output logic         core_take,
   dhc_rsp_if.source    rsp_ch
);

   logic [2:0]       mode_ff, mode_in;
   logic [14:0]      avg_ff, avg_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             beacon_ff, beacon_in;
   logic             pending_ff, pending_in;
   logic [31:0]      change_stamp_ff, change_stamp_in;
   logic [31:0]      entry_ff, entry_in;
   logic             charger_ff, charger_in;
   logic             led_ff, led_in;
   logic             pulse;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_state_ff;
   logic             rsp_charger_ff;
   logic             rsp_led_ff;
   logic             rsp_pulse_ff;
   logic [14:0]      rsp_rail_ff;

   logic [SUM_W-1:0]      new_sum;
   logic [AVG_PROD_W-1:0] avg_prod;
   logic [AVG_PROD_W-1:0] avg_quot;
   logic [31:0]           elapsed;
   logic                  lost;
   logic                  advance;

   assign core_take = !rsp_valid_ff || rsp_ch.ready;
   assign advance = tick_valid && core_take;

   assign new_sum = sum_ff + SUM_W'(tick.mv);
   assign avg_prod = AVG_PROD_W'(new_sum) * AVG_PROD_W'(AVG_RECIP);
   assign avg_quot = avg_prod >> AVG_SHIFT;
   assign elapsed = tick.now_ms - entry_ff;

   always_comb begin
      sum_in = new_sum;
      count_in = count_ff + CNT_W'(1);
      avg_in = avg_ff;
      if (count_ff == CNT_W'(AVG_SAMPLES - 1)) begin
         avg_in = avg_quot[14:0];
         sum_in = '0;
         count_in = '0;
      end

      beacon_in = beacon_ff;
      pending_in = pending_ff;
      change_stamp_in = change_stamp_ff;
      if (tick.beacon_level != beacon_ff) begin
         if (!pending_ff) begin
            pending_in = 1'b1;
            change_stamp_in = tick.now_ms;
         end else if ((tick.now_ms - change_stamp_ff) >= 32'(cfg.debounce_ms)) begin
            beacon_in = tick.beacon_level;
            pending_in = 1'b0;
         end
      end else begin
         pending_in = 1'b0;
      end

      lost = 16'(avg_in) < cfg.lost_threshold_mv;
      mode_in = mode_ff;
      entry_in = entry_ff;
      charger_in = charger_ff;
      led_in = led_ff;
      pulse = 1'b0;

      unique case (mode_ff)
         MODE_SEARCHING: begin
            charger_in = 1'b0;
            led_in = 1'b0;
            if (beacon_in) begin
               mode_in = MODE_ALIGNING;
               entry_in = tick.now_ms;
            end
         end
         MODE_ALIGNING: begin
            led_in = 1'b1;
            if (16'(avg_in) >= cfg.present_threshold_mv && beacon_in) begin
               mode_in = MODE_DOCKED;
               entry_in = tick.now_ms;
            end
            if (!beacon_in && elapsed > cfg.align_timeout_ms) begin
               mode_in = MODE_SEARCHING;
               entry_in = tick.now_ms;
            end
         end
         MODE_DOCKED: begin
            led_in = 1'b1;
            charger_in = 1'b1;
            if (elapsed > DOCK_SETTLE_MS) begin
               mode_in = MODE_CHARGING;
               entry_in = tick.now_ms;
            end
            if (lost && elapsed > cfg.lost_timeout_ms) begin
               mode_in = MODE_SEARCHING;
               charger_in = 1'b0;
               entry_in = tick.now_ms;
            end
         end
         MODE_CHARGING: begin
            led_in = tick.blink;
            if (tick.battery_pct >= cfg.full_charge_pct || elapsed > cfg.max_charge_ms) begin
               mode_in = MODE_STANDBY;
               entry_in = tick.now_ms;
            end
            if (lost && elapsed > cfg.lost_timeout_ms) begin
               mode_in = MODE_SEARCHING;
               charger_in = 1'b0;
               entry_in = tick.now_ms;
            end
         end
         MODE_STANDBY: begin
            led_in = 1'b1;
            if (elapsed > cfg.standby_ms) begin
               pulse = 1'b1;
               mode_in = MODE_SEARCHING;
               entry_in = tick.now_ms;
            end
            if (lost) begin
               mode_in = MODE_SEARCHING;
               charger_in = 1'b0;
               entry_in = tick.now_ms;
            end
         end
         default: begin
            mode_in = MODE_SEARCHING;
            entry_in = tick.now_ms;
         end
      endcase

      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SEARCHING;
         avg_ff <= '0;
         sum_ff <= '0;
         count_ff <= '0;
         beacon_ff <= 1'b0;
         pending_ff <= 1'b0;
         change_stamp_ff <= '0;
         entry_ff <= '0;
         charger_ff <= 1'b0;
         led_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            mode_ff <= mode_in;
            avg_ff <= avg_in;
            sum_ff <= sum_in;
            count_ff <= count_in;
            beacon_ff <= beacon_in;
            pending_ff <= pending_in;
            change_stamp_ff <= change_stamp_in;
            entry_ff <= entry_in;
            charger_ff <= charger_in;
            led_ff <= led_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_state_ff <= mode_in;
         rsp_charger_ff <= charger_in;
         rsp_led_ff <= led_in;
         rsp_pulse_ff <= pulse;
         rsp_rail_ff <= avg_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.dock_state = rsp_state_ff;
   assign rsp_ch.charger_on = rsp_charger_ff;
   assign rsp_ch.led_on = rsp_led_ff;
   assign rsp_ch.standby_pulse = rsp_pulse_ff;
   assign rsp_ch.rail_mv = rsp_rail_ff;

   a_align_charger_off: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_ALIGNING |-> !charger_ff)
      else $error("charger enabled while aligning");

   a_pulse_to_search: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_pulse_ff |-> rsp_state_ff == MODE_SEARCHING)
      else $error("standby pulse without return to searching");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(AVG_SAMPLES - 1))
      else $error("sample count past block length");

   a_entry_stamp: assert property (@(posedge clock) disable iff (reset)
      advance && mode_in != mode_ff |=> entry_ff == $past(tick.now_ms))
      else $error("state change without timer restart");

endmodule

/* hdl/dock_handshake_controller.sv */
// ----------------------------------------------------------------------------
// dock_handshake_controller
// Dock state machine with rail averaging, beacon debounce and charger control.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one tick per transaction: timestamp, raw rail sample with
//   its ok flag, active-low beacon level and battery percent. rsp_ch returns
//   exactly one transaction per tick: dock state, charger and LED levels, the
//   standby pulse and the latest block-averaged rail voltage.
//   csr_we/csr_index/csr_wdata write the eight settings; write them only
//   while no tick is in flight.
//   A tick accepted sits in the input register; its result is then
//   registered in the result register, from which it can be taken.
//   One tick per cycle is sustained while rsp_ch does not stall: the
//   state update is a single pass between the two registers.
//   Reset (synchronous) loads the default settings, returns to searching and
//   clears the averager, debounce and timers.
//   When rsp_ch stalls, the result holds and one more tick is parked in the
//   input register; req_ch.ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module dock_handshake_controller
   import dhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dhc_req_if.sink     req_ch,
   dhc_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   dhc_cfg_type  cfg;
   dhc_tick_type tick;
   logic         tick_valid;
   logic         core_take;

   dhc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dhc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .core_take  (core_take),
      .tick_valid (tick_valid),
      .tick       (tick)
   );

   dhc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .tick_valid (tick_valid),
      .tick       (tick),
      .core_take  (core_take),
      .rsp_ch     (rsp_ch)
   );

endmodule

/* test/dock_status_checker.sv */
// ----------------------------------------------------------------------------
// dock_status_checker
// Watches the tick and status channels of the dock handshake controller. It
// keeps its own copy of the settings and the dock state, predicts the status
// of every accepted tick and compares each returned status, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module dock_status_checker
   import dhc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dhc_req_if          req_ch,
   dhc_rsp_if          rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          status_waiting,
   output int          status_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [2:0]  dock_state;
      logic        charger_on;
      logic        led_on;
      logic        standby_pulse;
      logic [14:0] rail_mv;
   } dock_status_t;

   dhc_cfg_type  settings;
   logic [2:0]   mode;
   logic [14:0]  rail_avg;
   logic [16:0]  rail_sum;
   int           rail_count;
   logic         beacon;
   logic         beacon_pending;
   logic [31:0]  beacon_stamp;
   logic [31:0]  mode_stamp;
   logic         charger;
   logic         led;
   dock_status_t expected_status[$];
   int           mismatches = 0;
   int           checked = 0;

   function automatic dock_status_t next_status(input logic [31:0] now,
                                                input logic [11:0] adc,
                                                input logic        adc_ok,
                                                input logic        ir_pin,
                                                input logic [6:0]  battery);
      logic [31:0] elapsed;
      logic [31:0] sample_mv;
      logic [31:0] half_secs;
      logic [2:0]  next_mode;
      logic        pulse;
      logic        level;
      logic        lost;
      elapsed = now - mode_stamp;
      next_mode = mode;
      pulse = 1'b0;

      sample_mv = adc_ok ? ((32'(adc) * 32'd20889 + 32'd2048) >> 12) : 32'd0;
      rail_sum = rail_sum + sample_mv[16:0];
      rail_count++;
      if (rail_count >= AVG_SAMPLES) begin
         rail_avg = 15'(32'(rail_sum) / AVG_SAMPLES);
         rail_sum = '0;
         rail_count = 0;
      end

      // beacon is active low; a pending flag marks a running debounce
      level = ~ir_pin;
      if (level != beacon) begin
         if (!beacon_pending) begin
            beacon_pending = 1'b1;
            beacon_stamp = now;
         end else if (now - beacon_stamp >= 32'(settings.debounce_ms)) begin
            beacon = level;
            beacon_pending = 1'b0;
         end
      end else begin
         beacon_pending = 1'b0;
      end
      lost = rail_avg < settings.lost_threshold_mv;

      // later checks override earlier ones
      case (mode)
         MODE_SEARCHING: begin
            charger = 1'b0;
            led = 1'b0;
            if (beacon) begin
               next_mode = MODE_ALIGNING;
               mode_stamp = now;
            end
         end
         MODE_ALIGNING: begin
            led = 1'b1;
            if (rail_avg >= settings.present_threshold_mv && beacon) begin
               next_mode = MODE_DOCKED;
               mode_stamp = now;
            end
            if (!beacon && elapsed > settings.align_timeout_ms) begin
               next_mode = MODE_SEARCHING;
               mode_stamp = now;
            end
         end
         MODE_DOCKED: begin
            led = 1'b1;
            charger = 1'b1;
            if (elapsed > DOCK_SETTLE_MS) begin
               next_mode = MODE_CHARGING;
               mode_stamp = now;
            end
            if (lost && elapsed > settings.lost_timeout_ms) begin
               next_mode = MODE_SEARCHING;
               charger = 1'b0;
               mode_stamp = now;
            end
         end
         MODE_CHARGING: begin
            half_secs = now / 32'd500;
            led = half_secs[0];
            if (battery >= settings.full_charge_pct) begin
               next_mode = MODE_STANDBY;
               mode_stamp = now;
            end
            if (elapsed > settings.max_charge_ms) begin
               next_mode = MODE_STANDBY;
               mode_stamp = now;
            end
            if (lost && elapsed > settings.lost_timeout_ms) begin
               next_mode = MODE_SEARCHING;
               charger = 1'b0;
               mode_stamp = now;
            end
         end
         MODE_STANDBY: begin
            led = 1'b1;
            if (elapsed > settings.standby_ms) begin
               pulse = 1'b1;
               next_mode = MODE_SEARCHING;
               mode_stamp = now;
            end
            if (lost) begin
               next_mode = MODE_SEARCHING;
               charger = 1'b0;
               mode_stamp = now;
            end
         end
         default: begin
            next_mode = MODE_SEARCHING;
            mode_stamp = now;
         end
      endcase
      mode = next_mode;

      return '{dock_state: mode, charger_on: charger, led_on: led,
               standby_pulse: pulse, rail_mv: rail_avg};
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      dock_status_t seen;
      dock_status_t want;
      if (reset) begin
         settings = '{present_threshold_mv: 16'd15000, lost_threshold_mv: 16'd5000,
                      debounce_ms: 16'd50, lost_timeout_ms: 32'd1000,
                      full_charge_pct: 7'd98, align_timeout_ms: 32'd500,
                      max_charge_ms: 32'd21600000, standby_ms: 32'd60000};
         mode = MODE_SEARCHING;
         rail_avg = '0;
         rail_sum = '0;
         rail_count = 0;
         beacon = 1'b0;
         beacon_pending = 1'b0;
         beacon_stamp = '0;
         mode_stamp = '0;
         charger = 1'b0;
         led = 1'b0;
         expected_status.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen = '{rsp_ch.dock_state, rsp_ch.charger_on, rsp_ch.led_on,
                     rsp_ch.standby_pulse, rsp_ch.rail_mv};
            if (expected_status.size() == 0) begin
               $display("%0t: status transaction with no tick outstanding, actual %h",
                        $time, seen);
               mismatches++;
            end else begin
               want = expected_status.pop_front();
               check_field("dock_state", want.dock_state, seen.dock_state);
               check_field("charger_on", want.charger_on, seen.charger_on);
               check_field("led_on", want.led_on, seen.led_on);
               check_field("standby_pulse", want.standby_pulse, seen.standby_pulse);
               check_field("rail_mv", want.rail_mv, seen.rail_mv);
               checked++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               REG_PRESENT_THRESHOLD: settings.present_threshold_mv = csr_wdata[15:0];
               REG_LOST_THRESHOLD:    settings.lost_threshold_mv = csr_wdata[15:0];
               REG_DEBOUNCE:          settings.debounce_ms = csr_wdata[15:0];
               REG_LOST_TIMEOUT:      settings.lost_timeout_ms = csr_wdata;
               REG_FULL_CHARGE:       settings.full_charge_pct = csr_wdata[6:0];
               REG_ALIGN_TIMEOUT:     settings.align_timeout_ms = csr_wdata;
               REG_MAX_CHARGE:        settings.max_charge_ms = csr_wdata;
               REG_STANDBY:           settings.standby_ms = csr_wdata;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            expected_status.push_back(next_status(req_ch.now_ms, req_ch.adc_sample,
                                                  req_ch.adc_ok, req_ch.ir_pin,
                                                  req_ch.battery_pct));
      end
      mismatch_count <= mismatches;
      status_waiting <= expected_status.size();
      status_checked <= checked;
   end

endmodule

/* test/tb_dock_handshake_controller.sv */
// ----------------------------------------------------------------------------
// tb_dock_handshake_controller
// Regression for the dock handshake controller. A short directed run walks
// the dock cycle through its corner cases, then docking episodes with random
// content, mixed with noise ticks, run under several register settings with
// random idling on both channels. The checker predicts every status.
// ----------------------------------------------------------------------------
module tb_dock_handshake_controller
   import dhc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum int {SET_QUICK, SET_FLOOR, SET_CEILING, SET_DEFAULT, SET_MIXED}
      setting_kind_type;

   localparam int PHASE_TICKS = 65;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          mismatch_count;
   int          status_waiting;
   int          status_checked;

   bit          quiet = 1'b0;
   logic [31:0] tick_ms = '0;
   int          total_ticks = 0;
   int          settings_loaded = 0;
   int          stalled_cycles = 0;

   dhc_req_if req_ch();
   dhc_rsp_if rsp_ch();

   dock_handshake_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dock_status_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .status_waiting (status_waiting),
      .status_checked (status_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_tick(input logic [31:0] now, input logic [11:0] adc,
                            input logic ok, input logic pin, input logic [6:0] battery);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.now_ms <= now;
      req_ch.adc_sample <= adc;
      req_ch.adc_ok <= ok;
      req_ch.ir_pin <= pin;
      req_ch.battery_pct <= battery;
      do @(posedge clock); while (!req_ch.ready);
      total_ticks++;
   endtask

   // lets every outstanding status drain before the registers change
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (status_waiting != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [2:0] index, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(input dhc_cfg_type s);
      put_reg(REG_PRESENT_THRESHOLD, {16'($urandom), s.present_threshold_mv});
      put_reg(REG_LOST_THRESHOLD, {16'($urandom), s.lost_threshold_mv});
      put_reg(REG_DEBOUNCE, {16'($urandom), s.debounce_ms});
      put_reg(REG_LOST_TIMEOUT, s.lost_timeout_ms);
      put_reg(REG_FULL_CHARGE, {25'($urandom), s.full_charge_pct});
      put_reg(REG_ALIGN_TIMEOUT, s.align_timeout_ms);
      put_reg(REG_MAX_CHARGE, s.max_charge_ms);
      put_reg(REG_STANDBY, s.standby_ms);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   function automatic logic [31:0] pick_span(input int unsigned lo, input int unsigned hi,
                                             input logic [31:0] ceiling);
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return ceiling;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   function automatic dhc_cfg_type pick_settings(input setting_kind_type kind);
      dhc_cfg_type s;
      case (kind)
         SET_FLOOR: s = '0;
         SET_CEILING: begin
            s = '1;
         end
         SET_DEFAULT: begin
            s = '{present_threshold_mv: 16'd15000, lost_threshold_mv: 16'd5000,
                  debounce_ms: 16'd50, lost_timeout_ms: 32'd1000,
                  full_charge_pct: 7'd98, align_timeout_ms: 32'd500,
                  max_charge_ms: 32'd21600000, standby_ms: 32'd60000};
         end
         SET_MIXED: begin
            s.present_threshold_mv = 16'(pick_span(10000, 16000, 32'hFFFF));
            s.lost_threshold_mv = 16'(pick_span(2000, 6000, 32'hFFFF));
            s.debounce_ms = 16'(pick_span(0, 40, 32'hFFFF));
            s.lost_timeout_ms = pick_span(0, 400, '1);
            s.full_charge_pct = 7'(pick_span(60, 100, 32'h7F));
            s.align_timeout_ms = pick_span(0, 300, '1);
            s.max_charge_ms = pick_span(300, 3000, '1);
            s.standby_ms = pick_span(0, 800, '1);
         end
         default: begin
            s.present_threshold_mv = 16'($urandom_range(10000, 16000));
            s.lost_threshold_mv = 16'($urandom_range(2000, 6000));
            s.debounce_ms = 16'($urandom_range(0, 40));
            s.lost_timeout_ms = $urandom_range(0, 400);
            s.full_charge_pct = 7'($urandom_range(60, 100));
            s.align_timeout_ms = $urandom_range(0, 300);
            s.max_charge_ms = $urandom_range(300, 3000);
            s.standby_ms = $urandom_range(0, 800);
         end
      endcase
      return s;
   endfunction

   // one approach to the dock: beacon window, powered rail with an optional
   // drop, rising battery; one in five is pure noise
   task automatic run_episode();
      int          len;
      int          beacon_on;
      int          beacon_off;
      int          drop_at;
      int          batt_start;
      int          rate;
      int          batt_level;
      bit          noisy;
      logic        pin;
      logic [11:0] adc;
      noisy = ($urandom_range(0, 4) == 0);
      quiet = ($urandom_range(0, 4) == 0);
      len = $urandom_range(12, 60);
      beacon_on = $urandom_range(0, 4);
      beacon_off = $urandom_range(len / 2, len + 5);
      drop_at = ($urandom_range(0, 2) == 0) ? $urandom_range(5, len) : len + 1;
      batt_start = $urandom_range(0, 100);
      rate = $urandom_range(0, 5);
      for (int i = 0; i < len; i++) begin
         if (noisy) begin
            tick_ms = $urandom;
            send_tick(tick_ms, 12'($urandom), 1'($urandom), 1'($urandom), 7'($urandom));
         end else begin
            tick_ms += ($urandom_range(0, 39) == 0) ? $urandom : $urandom_range(0, 120);
            pin = (i >= beacon_on && i < beacon_off) ? 1'b0 : 1'b1;
            if ($urandom_range(0, 11) == 0)
               pin = ~pin;
            adc = (i < drop_at) ? 12'($urandom_range(2900, 4095))
                                : 12'($urandom_range(0, 900));
            batt_level = batt_start + i * rate;
            if (batt_level > 127)
               batt_level = 127;
            send_tick(tick_ms, adc, $urandom_range(0, 15) != 0, pin, 7'(batt_level));
         end
      end
   endtask

   initial begin
      int stall;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("dock_handshake_controller regression: fail");
         $finish;
      end
   end

   initial begin
      setting_kind_type phase_plan[7];
      int               phase_start;
      phase_plan = '{SET_QUICK, SET_FLOOR, SET_QUICK, SET_CEILING, SET_DEFAULT,
                     SET_MIXED, SET_MIXED};
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.now_ms <= '0;
      req_ch.adc_sample <= '0;
      req_ch.adc_ok <= 1'b0;
      req_ch.ir_pin <= 1'b1;
      req_ch.battery_pct <= '0;
      csr_we <= 1'b0;
      csr_index <= REG_PRESENT_THRESHOLD;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: beacon seen at timestamp zero, dock, charge to full,
      // then standby timeout together with power loss, then a wrapped debounce
      send_tick(32'd0, 12'd0, 1'b1, 1'b0, 7'd0);
      send_tick(32'd30, 12'd4095, 1'b0, 1'b0, 7'd0);
      send_tick(32'd50, 12'd4095, 1'b1, 1'b0, 7'd0);
      send_tick(32'd60, 12'd4095, 1'b1, 1'b0, 7'd0);
      send_tick(32'd70, 12'd4095, 1'b1, 1'b0, 7'd10);
      send_tick(32'd80, 12'd4095, 1'b1, 1'b0, 7'd10);
      send_tick(32'd90, 12'd4095, 1'b1, 1'b0, 7'd10);
      send_tick(32'd100, 12'd4095, 1'b1, 1'b0, 7'd10);
      send_tick(32'd200, 12'd4095, 1'b1, 1'b0, 7'd10);
      send_tick(32'd301, 12'd4095, 1'b1, 1'b0, 7'd10);
      send_tick(32'd800, 12'd4095, 1'b1, 1'b0, 7'd50);
      send_tick(32'd1000, 12'd4095, 1'b1, 1'b0, 7'd100);
      send_tick(32'd2000, 12'd0, 1'b1, 1'b0, 7'd127);
      send_tick(32'd3000, 12'd4095, 1'b0, 1'b0, 7'd127);
      send_tick(32'd4000, 12'd4095, 1'b0, 1'b0, 7'd127);
      send_tick(32'd61001, 12'd4095, 1'b0, 1'b0, 7'd127);
      send_tick(32'd61100, 12'd4095, 1'b1, 1'b1, 7'd0);
      send_tick(32'hFFFF_FFF0, 12'd4095, 1'b1, 1'b1, 7'd100);
      send_tick(32'hFFFF_FFFF, 12'd4095, 1'b1, 1'b0, 7'd0);
      send_tick(32'd49, 12'd4095, 1'b1, 1'b0, 7'd0);
      send_tick(32'd100, 12'd4095, 1'b1, 1'b0, 7'd0);
      send_tick(32'd1500, 12'd0, 1'b1, 1'b0, 7'd20);
      send_tick(32'd1750, 12'd2048, 1'b1, 1'b0, 7'd20);
      settle();

      foreach (phase_plan[p]) begin
         load_settings(pick_settings(phase_plan[p]));
         phase_start = total_ticks;
         while (total_ticks - phase_start < PHASE_TICKS)
            run_episode();
         settle();
      end

      $display("%0d ticks sent under %0d register settings plus the reset values",
               total_ticks, settings_loaded);
      $display("%0d status transactions checked, %0d mismatches",
               status_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("dock_handshake_controller regression: pass");
      else
         $display("dock_handshake_controller regression: fail");
      $finish;
   end

endmodule
